// ===== rtl/core/tkam_pkg.sv =====
// Shared constants and types for the top-k argmax selector.
// No dependencies; imported by the selector core.
`default_nettype none

package tkam_pkg;

    localparam int TOPK_MAX   = 8;
    localparam int VECTOR_MAX = 4096;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = $clog2(VECTOR_MAX);
    localparam int RANK_W     = $clog2(TOPK_MAX);
    localparam int TOPK_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int M_DATA_W   = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX_VAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_AXIS    = 2'd2;

    // result phase codes
    localparam logic PHASE_INDEX = 1'b0;
    localparam logic PHASE_VALUE = 1'b1;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [TOPK_W-1:0] TOPK_SAT = TOPK_W'(TOPK_MAX);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [RANK_W-1:0]         rank_t;

    typedef struct packed {
        logic   valid;
        value_t value;
        pos_t   index;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/top_k_argmax_selector.sv =====
// Top level of the top-k argmax selector: ranked insert list, result bank
// and result sequencer. Depends on tkam_pkg.
`default_nettype none

// Streams one signed Q16.16 element per cycle and keeps the TOPK_MAX largest
// values with their positions; equal values rank the later position higher.
// Each element is held in the input register, then updates the ranked list
// with eight parallel compares and a shift-insert, so one element is taken
// every cycle. On a vector's last element the list is copied into a result
// bank and cleared; the bank sends its results one per cycle while m_tready
// is high (top_k, or 2*top_k in flat value mode), the first once the bank is
// loaded. A new vector streams in while the bank drains; only its last
// element waits until the bank is free (or frees in the same cycle). Ranks
// beyond the vector length report index 0 and the most negative value.
// Configuration is sampled when a vector ends.
module top_k_argmax_selector
    import tkam_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // element stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] elem_value
    input  wire logic                  s_tlast,   // elem_last
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [31:0] result_word, [34:32] rank
    output logic                       m_tuser,   // is_value
    output logic                       m_tlast    // run_last
);

    // configuration registers
    logic [TOPK_W-1:0] top_k_reg;
    logic              out_max_val_reg;
    logic              has_axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_reg       <= TOPK_W'(1);
            out_max_val_reg <= 1'b0;
            has_axis_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TOP_K:       top_k_reg       <= cfg_wdata;
                CFG_OUT_MAX_VAL: out_max_val_reg <= cfg_wdata[0];
                CFG_HAS_AXIS:    has_axis_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    logic   in_valid_reg;
    value_t in_value_reg;
    logic   in_last_reg;

    // working list and position
    entry_t list_reg  [TOPK_MAX];
    entry_t list_next [TOPK_MAX];
    pos_t   pos_reg;

    // result bank and sequencer
    logic   bank_busy_reg;
    value_t bank_val_reg [TOPK_MAX];
    pos_t   bank_idx_reg [TOPK_MAX];
    rank_t  bank_klast_reg;
    logic   bank_omv_reg;
    logic   phase_reg;
    rank_t  rank_reg;

    logic              advance;
    logic              bank_load;
    logic              bank_free;
    logic              out_fire;
    logic              rank_end;
    logic              run_last;
    logic [TOPK_W-1:0] k_eff;
    logic              ge [TOPK_MAX];

    assign out_fire  = m_tvalid && m_tready;
    assign rank_end  = (rank_reg == bank_klast_reg);
    assign run_last  = rank_end && (phase_reg == PHASE_VALUE || !bank_omv_reg);
    assign bank_free = !bank_busy_reg || (out_fire && run_last);
    assign advance   = in_valid_reg && (!in_last_reg || bank_free);
    assign bank_load = advance && in_last_reg;
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        if (top_k_reg == '0) begin
            k_eff = TOPK_W'(1);
        end else if (top_k_reg > TOPK_SAT) begin
            k_eff = TOPK_SAT;
        end else begin
            k_eff = top_k_reg;
        end
    end

    // rank i takes the new element or shifts down once the element ranks at or above it
    always_comb begin
        for (int i = 0; i < TOPK_MAX; i++) begin
            ge[i] = !list_reg[i].valid || (in_value_reg >= list_reg[i].value);
        end
        list_next[0] = list_reg[0];
        if (ge[0]) begin
            list_next[0].valid = 1'b1;
            list_next[0].value = in_value_reg;
            list_next[0].index = pos_reg;
        end
        for (int i = 1; i < TOPK_MAX; i++) begin
            list_next[i] = list_reg[i];
            if (ge[i]) begin
                if (!ge[i-1]) begin
                    list_next[i].valid = 1'b1;
                    list_next[i].value = in_value_reg;
                    list_next[i].index = pos_reg;
                end else begin
                    list_next[i] = list_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < TOPK_MAX; i++) begin
                list_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            if (in_last_reg) begin
                // vector done: clear the list for the next one
                pos_reg <= '0;
                for (int i = 0; i < TOPK_MAX; i++) begin
                    list_reg[i].valid <= 1'b0;
                end
            end else begin
                if (pos_reg != POS_W'(VECTOR_MAX - 1)) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                for (int i = 0; i < TOPK_MAX; i++) begin
                    list_reg[i].valid <= list_next[i].valid;
                end
            end
        end
        if (advance) begin
            for (int i = 0; i < TOPK_MAX; i++) begin
                list_reg[i].value <= list_next[i].value;
                list_reg[i].index <= list_next[i].index;
            end
        end
    end

    // result bank: snapshot of the updated list, empty ranks forced to defaults
    always_ff @(posedge aclk) begin
        if (bank_load) begin
            for (int i = 0; i < TOPK_MAX; i++) begin
                bank_val_reg[i] <= list_next[i].valid ? list_next[i].value : VALUE_MIN;
                bank_idx_reg[i] <= list_next[i].valid ? list_next[i].index : '0;
            end
            bank_klast_reg <= RANK_W'(k_eff - TOPK_W'(1));
            bank_omv_reg   <= out_max_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_busy_reg <= 1'b0;
            phase_reg     <= PHASE_INDEX;
            rank_reg      <= '0;
        end else if (bank_load) begin
            bank_busy_reg <= 1'b1;
            phase_reg     <= (out_max_val_reg && has_axis_reg) ? PHASE_VALUE : PHASE_INDEX;
            rank_reg      <= '0;
        end else if (out_fire) begin
            if (run_last) begin
                bank_busy_reg <= 1'b0;
            end else if (rank_end) begin
                // index list done, move on to the value list
                phase_reg <= PHASE_VALUE;
                rank_reg  <= '0;
            end else begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    logic [VALUE_W-1:0] result_word;

    always_comb begin
        if (phase_reg == PHASE_VALUE) begin
            result_word = bank_val_reg[rank_reg];
        end else begin
            result_word = VALUE_W'(bank_idx_reg[rank_reg]);
        end
    end

    assign m_tvalid = bank_busy_reg;
    assign m_tdata  = {{(M_DATA_W - VALUE_W - RANK_W){1'b0}}, rank_reg, result_word};
    assign m_tuser  = phase_reg;
    assign m_tlast  = run_last;

endmodule

`default_nettype wire
